[rtl/frpf_pkg.sv]
package frpf_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_HDR1,
		ST_HDR2,
		ST_LEN_LO,
		ST_LEN_HI,
		ST_POP_CHK,
		ST_POP_OUT,
		ST_EMIT
	} frpf_state_t;

	typedef enum logic [1:0] {
		KIND_PUSH_OK,
		KIND_PUSH_REJ,
		KIND_POP_BYTE,
		KIND_POP_EMPTY
	} frpf_kind_t;

	localparam int LEN_W   = 7;
	localparam int BYTE_W  = 8;
	localparam int PLEN_W  = 16;
	localparam int CHECK_W = 18;

endpackage

[rtl/framed_packet_ring_fifo.sv]
// push: a byte is taken while idle; a first push byte also writes the two-byte length header
// before the next byte is taken; a push result is offered once its packet is stored or rejected
// pop: the 2-byte header is fetched and checked (skipped when fewer than 2 bytes are stored),
// then one byte per cycle while out_ready is high; the ram has one write and one read port
// reset: arst_n clears head, tail, write position, fill and remaining counts and control; ring storage is not cleared
module framed_packet_ring_fifo #(
	parameter int RING_BYTES    = 4096,
	parameter int MAX_PACKET    = 64,
	parameter int MAX_POP_BYTES = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       operation,
	input  logic       first_byte,
	input  logic [6:0] packet_len,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] kind,
	output logic [7:0] out_byte,
	output logic [6:0] out_len,
	output logic       last_of_run
);

	localparam int PW = $clog2(2 * RING_BYTES);
	localparam int AW = $clog2(RING_BYTES);
	localparam logic [PW:0]   POS_MOD = (PW + 1)'(2 * RING_BYTES);
	localparam logic [PW-1:0] RING_PW = PW'(RING_BYTES);
	localparam int LW = frpf_pkg::LEN_W;
	localparam int BW = frpf_pkg::BYTE_W;
	localparam int HW = frpf_pkg::PLEN_W;
	localparam int CW = frpf_pkg::CHECK_W;

	function automatic logic [PW-1:0] pos_add(input logic [PW-1:0] p, input logic [PW-1:0] n);
		logic [PW:0] s;
		s = {1'b0, p} + {1'b0, n};
		if (s >= POS_MOD) begin
			s = s - POS_MOD;
		end
		return s[PW-1:0];
	endfunction

	function automatic logic [AW-1:0] addr_of(input logic [PW-1:0] p);
		logic [PW-1:0] a;
		a = (p >= RING_PW) ? p - RING_PW : p;
		return a[AW-1:0];
	endfunction

	frpf_pkg::frpf_state_t state_q, state_d;
	frpf_pkg::frpf_kind_t  res_q, res_d;
	frpf_pkg::frpf_kind_t  kind_q, kind_d;

	logic [PW-1:0] head_q, head_d;
	logic [PW-1:0] tail_q, tail_d;
	logic [PW-1:0] pos_q, pos_d;
	logic [PW-1:0] used_q, used_d;
	logic [PW-1:0] rdpos_q, rdpos_d;
	logic [LW-1:0] rem_q, rem_d;
	logic          drop_q, drop_d;
	logic [BW-1:0] data_q, data_d;
	logic [LW-1:0] plen_q, plen_d;
	logic [BW-1:0] lo_q, lo_d;
	logic [HW-1:0] poplen_q, poplen_d;
	logic [LW-1:0] cnt_q, cnt_d;

	logic          out_valid_q;
	logic [BW-1:0] out_byte_q, out_byte_d;
	logic [LW-1:0] out_len_q, out_len_d;
	logic          last_q, last_d;
	logic          out_load;

	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [BW-1:0] ram_wdata, ram_rdata;

	logic          in_accept;
	logic          slot_free;
	logic [LW-1:0] rem_dec;
	logic [PW-1:0] cont_pos;
	logic [PW-1:0] head1, head2, head3;
	logic [PW-1:0] tail2;
	logic [PW-1:0] rd_next;
	logic [HW:0]   len_plus2;
	logic [PW-1:0] tail_end;
	logic [PW-1:0] push_size;
	logic [CW-1:0] room_need;
	logic          reject;
	logic          pop_short;
	logic [LW-1:0] shown;

	frpf_ram #(
		.WIDTH(BW),
		.DEPTH(RING_BYTES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign in_ready  = (state_q == frpf_pkg::ST_IDLE);
	assign in_accept = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;

	assign rem_dec   = rem_q - LW'(1);
	assign cont_pos  = pos_add(pos_q, PW'(1));
	assign head1     = pos_add(head_q, PW'(1));
	assign head2     = pos_add(head_q, PW'(2));
	assign head3     = pos_add(head_q, PW'(3));
	assign tail2     = pos_add(tail_q, PW'(2));
	assign rd_next   = pos_add(rdpos_q, PW'(1));
	assign len_plus2 = {1'b0, poplen_q} + (HW + 1)'(2);
	assign tail_end  = pos_add(tail_q, PW'(len_plus2));
	assign push_size = PW'(plen_q) + PW'(2);
	assign room_need = CW'(used_q) + CW'(packet_len) + CW'(2);
	assign reject    = (packet_len == '0) || (packet_len > LW'(MAX_PACKET))
		|| (room_need > CW'(RING_BYTES));
	assign pop_short = CW'(used_q) < CW'(len_plus2);
	assign shown     = (poplen_q < HW'(MAX_POP_BYTES)) ? poplen_q[LW-1:0]
		: LW'(MAX_POP_BYTES);

	always_comb begin
		state_d    = state_q;
		res_d      = res_q;
		head_d     = head_q;
		tail_d     = tail_q;
		pos_d      = pos_q;
		used_d     = used_q;
		rdpos_d    = rdpos_q;
		rem_d      = rem_q;
		drop_d     = drop_q;
		data_d     = data_q;
		plen_d     = plen_q;
		lo_d       = lo_q;
		poplen_d   = poplen_q;
		cnt_d      = cnt_q;
		out_load   = 1'b0;
		kind_d     = res_q;
		out_byte_d = '0;
		out_len_d  = '0;
		last_d     = 1'b1;
		ram_we     = 1'b0;
		ram_waddr  = addr_of(head_q);
		ram_wdata  = '0;
		ram_re     = 1'b0;
		ram_raddr  = addr_of(tail_q);

		unique case (state_q)
			frpf_pkg::ST_IDLE: begin
				if (in_accept) begin
					if (operation) begin
						if (used_q < PW'(2)) begin
							res_d   = frpf_pkg::KIND_POP_EMPTY;
							state_d = frpf_pkg::ST_EMIT;
						end else begin
							ram_re    = 1'b1;
							ram_raddr = addr_of(tail_q);
							state_d   = frpf_pkg::ST_LEN_LO;
						end
					end else if (first_byte) begin
						if (reject) begin
							drop_d  = (packet_len > LW'(1));
							rem_d   = (packet_len > LW'(1)) ? packet_len - LW'(1) : '0;
							res_d   = frpf_pkg::KIND_PUSH_REJ;
							state_d = frpf_pkg::ST_EMIT;
						end else begin
							ram_we    = 1'b1;
							ram_waddr = addr_of(head_q);
							ram_wdata = BW'(packet_len);
							drop_d    = 1'b0;
							rem_d     = packet_len - LW'(1);
							plen_d    = packet_len;
							data_d    = data_byte;
							state_d   = frpf_pkg::ST_HDR1;
						end
					end else if (rem_q != '0) begin
						rem_d = rem_dec;
						if (drop_q) begin
							if (rem_dec == '0) begin
								drop_d = 1'b0;
							end
						end else begin
							ram_we    = 1'b1;
							ram_waddr = addr_of(pos_q);
							ram_wdata = data_byte;
							pos_d     = cont_pos;
							if (rem_dec == '0) begin
								head_d  = cont_pos;
								used_d  = used_q + push_size;
								res_d   = frpf_pkg::KIND_PUSH_OK;
								state_d = frpf_pkg::ST_EMIT;
							end
						end
					end
				end
			end
			frpf_pkg::ST_HDR1: begin
				// high length byte, always zero for a 7-bit length
				ram_we    = 1'b1;
				ram_waddr = addr_of(head1);
				ram_wdata = '0;
				state_d   = frpf_pkg::ST_HDR2;
			end
			frpf_pkg::ST_HDR2: begin
				ram_we    = 1'b1;
				ram_waddr = addr_of(head2);
				ram_wdata = data_q;
				pos_d     = head3;
				if (rem_q == '0) begin
					head_d  = head3;
					used_d  = used_q + push_size;
					res_d   = frpf_pkg::KIND_PUSH_OK;
					state_d = frpf_pkg::ST_EMIT;
				end else begin
					state_d = frpf_pkg::ST_IDLE;
				end
			end
			frpf_pkg::ST_LEN_LO: begin
				lo_d      = ram_rdata;
				ram_re    = 1'b1;
				ram_raddr = addr_of(pos_add(tail_q, PW'(1)));
				state_d   = frpf_pkg::ST_LEN_HI;
			end
			frpf_pkg::ST_LEN_HI: begin
				poplen_d = {ram_rdata, lo_q};
				state_d  = frpf_pkg::ST_POP_CHK;
			end
			frpf_pkg::ST_POP_CHK: begin
				if (pop_short) begin
					res_d   = frpf_pkg::KIND_POP_EMPTY;
					state_d = frpf_pkg::ST_EMIT;
				end else if (poplen_q == '0) begin
					tail_d  = tail2;
					used_d  = used_q - PW'(2);
					res_d   = frpf_pkg::KIND_POP_EMPTY;
					state_d = frpf_pkg::ST_EMIT;
				end else begin
					cnt_d     = shown;
					rdpos_d   = tail2;
					ram_re    = 1'b1;
					ram_raddr = addr_of(tail2);
					state_d   = frpf_pkg::ST_POP_OUT;
				end
			end
			frpf_pkg::ST_POP_OUT: begin
				if (slot_free) begin
					out_load   = 1'b1;
					kind_d     = frpf_pkg::KIND_POP_BYTE;
					out_byte_d = ram_rdata;
					out_len_d  = poplen_q[LW-1:0];
					last_d     = (cnt_q == LW'(1));
					if (cnt_q == LW'(1)) begin
						tail_d  = tail_end;
						used_d  = used_q - PW'(len_plus2);
						state_d = frpf_pkg::ST_IDLE;
					end else begin
						cnt_d     = cnt_q - LW'(1);
						rdpos_d   = rd_next;
						ram_re    = 1'b1;
						ram_raddr = addr_of(rd_next);
					end
				end
			end
			frpf_pkg::ST_EMIT: begin
				if (slot_free) begin
					out_load = 1'b1;
					kind_d   = res_q;
					state_d  = frpf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = frpf_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= frpf_pkg::ST_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			pos_q       <= '0;
			used_q      <= '0;
			rem_q       <= '0;
			drop_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			pos_q   <= pos_d;
			used_q  <= used_d;
			rem_q   <= rem_d;
			drop_q  <= drop_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		res_q    <= res_d;
		rdpos_q  <= rdpos_d;
		data_q   <= data_d;
		plen_q   <= plen_d;
		lo_q     <= lo_d;
		poplen_q <= poplen_d;
		cnt_q    <= cnt_d;
		if (out_load) begin
			kind_q     <= kind_d;
			out_byte_q <= out_byte_d;
			out_len_q  <= out_len_d;
			last_q     <= last_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign out_byte    = out_byte_q;
	assign out_len     = out_len_q;
	assign last_of_run = last_q;

endmodule

[rtl/frpf_ram.sv]
module frpf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[tb/framed_packet_ring_fifo_test.sv]
`timescale 1ns / 100ps

module framed_packet_ring_fifo_test;

	localparam int RING = 4096;
	localparam int MAX_PKT = 64;
	localparam int MAX_POP = 64;
	localparam int RANDOM_ITEMS = 320;
	localparam int LONG_HOLD = 300;
	localparam int SETTLE = 16;
	localparam int STUCK_LIMIT = 2000;

	localparam bit OP_PUSH = 1'b0;
	localparam bit OP_POP = 1'b1;

	typedef struct {
		bit op;
		bit first;
		bit [6:0] plen;
		bit [7:0] data;
		int gap;
		bit drain;
		bit hold_out;
	} ring_req_t;

	typedef struct {
		frpf_pkg::frpf_kind_t kind;
		bit [7:0] data;
		bit [6:0] plen;
		bit last;
	} ring_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic operation = 1'b0;
	logic first_byte = 1'b0;
	logic [6:0] packet_len = 7'd0;
	logic [7:0] data_byte = 8'd0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] kind;
	logic [7:0] out_byte;
	logic [6:0] out_len;
	logic last_of_run;

	framed_packet_ring_fifo uut (.*);

	// shadow copy of the ring and its pointers
	bit [7:0] shadow_ring [RING];
	bit [12:0] head_pos;
	bit [12:0] tail_pos;
	bit [12:0] fill_pos;
	bit [6:0] fill_left;
	bit fill_drop;

	ring_req_t req_q [$];
	ring_res_t expected_out [$];
	ring_req_t cur;

	int errors;
	int items_sent;
	int results_seen;
	int gen_items;
	int n_push_ok;
	int n_push_rej;
	int n_room_rej;
	int n_pop_bytes;
	int n_pop_empty;
	bit next_drain;
	bit next_hold;
	bit no_gaps;

	int gap_left = 0;
	int quiet = 0;
	bit hold_req = 1'b0;
	int ready_left = 0;
	int stuck = 0;

	function automatic int stored_bytes();
		bit [12:0] d;
		d = head_pos - tail_pos;
		return int'(d);
	endfunction

	function automatic void expect_result(frpf_pkg::frpf_kind_t k, bit [7:0] d, bit [6:0] l,
		bit last);
		ring_res_t r;
		r.kind = k;
		r.data = d;
		r.plen = l;
		r.last = last;
		expected_out.push_back(r);
		case (k)
			frpf_pkg::KIND_PUSH_OK: n_push_ok++;
			frpf_pkg::KIND_PUSH_REJ: n_push_rej++;
			frpf_pkg::KIND_POP_BYTE: n_pop_bytes++;
			default: n_pop_empty++;
		endcase
	endfunction

	function automatic void predict_push(bit first, bit [6:0] plen, bit [7:0] data);
		bit [12:0] p;
		if (first) begin
			fill_drop = 1'b0;
			fill_left = 7'd0;
			if (plen == 0 || plen > MAX_PKT || RING - stored_bytes() < int'(plen) + 2) begin
				if (plen != 0 && plen <= MAX_PKT)
					n_room_rej++;
				if (plen > 1) begin
					fill_drop = 1'b1;
					fill_left = plen - 7'd1;
				end
				expect_result(frpf_pkg::KIND_PUSH_REJ, 8'd0, 7'd0, 1'b1);
				return;
			end
			shadow_ring[head_pos % RING] = {1'b0, plen};
			p = head_pos + 13'd1;
			shadow_ring[p % RING] = 8'd0;
			p = head_pos + 13'd2;
			shadow_ring[p % RING] = data;
			fill_pos = head_pos + 13'd3;
			fill_left = plen - 7'd1;
		end else begin
			if (fill_left == 0)
				return;
			fill_left = fill_left - 7'd1;
			if (fill_drop) begin
				if (fill_left == 0)
					fill_drop = 1'b0;
				return;
			end
			shadow_ring[fill_pos % RING] = data;
			fill_pos = fill_pos + 13'd1;
		end
		if (fill_left != 0)
			return;
		head_pos = fill_pos;
		expect_result(frpf_pkg::KIND_PUSH_OK, 8'd0, 7'd0, 1'b1);
	endfunction

	function automatic void predict_pop();
		int used;
		int plen;
		int shown;
		bit [12:0] p;
		used = stored_bytes();
		if (used < 2) begin
			expect_result(frpf_pkg::KIND_POP_EMPTY, 8'd0, 7'd0, 1'b1);
			return;
		end
		p = tail_pos + 13'd1;
		plen = {shadow_ring[p % RING], shadow_ring[tail_pos % RING]};
		if (used < plen + 2) begin
			expect_result(frpf_pkg::KIND_POP_EMPTY, 8'd0, 7'd0, 1'b1);
			return;
		end
		if (plen == 0) begin
			tail_pos = tail_pos + 13'd2;
			expect_result(frpf_pkg::KIND_POP_EMPTY, 8'd0, 7'd0, 1'b1);
			return;
		end
		shown = plen < MAX_POP ? plen : MAX_POP;
		for (int i = 0; i < shown; i++) begin
			p = tail_pos + 13'd2 + 13'(i);
			expect_result(frpf_pkg::KIND_POP_BYTE, shadow_ring[p % RING], 7'(plen),
				i == shown - 1);
		end
		tail_pos = tail_pos + 13'd2 + 13'(plen);
	endfunction

	function automatic void queue_req(bit op, bit first, bit [6:0] plen, bit [7:0] data);
		ring_req_t r;
		int pick;
		pick = $urandom_range(0, 99);
		r.op = op;
		r.first = first;
		r.plen = plen;
		r.data = data;
		r.gap = no_gaps ? 0 : pick < 70 ? 0 : pick < 95 ? $urandom_range(1, 3) :
			$urandom_range(8, 30);
		r.drain = next_drain;
		r.hold_out = next_hold;
		next_drain = 1'b0;
		next_hold = 1'b0;
		req_q.push_back(r);
		gen_items++;
	endfunction

	function automatic void queue_packet(bit [6:0] plen, int nbytes);
		queue_req(OP_PUSH, 1'b1, plen, 8'($urandom));
		for (int i = 1; i < nbytes; i++)
			queue_req(OP_PUSH, 1'b0, 7'($urandom), 8'($urandom));
	endfunction

	function automatic void queue_pop();
		queue_req(OP_POP, 1'($urandom), 7'($urandom), 8'($urandom));
	endfunction

	initial begin
		forever #1 clk = ~clk;
	end

	// sender
	always @(posedge clk or negedge arst_n) begin
		ring_req_t it;
		bit hold_next;
		hold_next = 1'b0;
		if (!arst_n) begin
			in_valid <= 1'b0;
			operation <= 1'b0;
			first_byte <= 1'b0;
			packet_len <= 7'd0;
			data_byte <= 8'd0;
			gap_left <= 0;
			quiet <= 0;
			hold_req <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				items_sent++;
				if (cur.op == OP_POP)
					predict_pop();
				else
					predict_push(cur.first, cur.plen, cur.data);
			end
			quiet <= expected_out.size() != 0 ? 0 : quiet < SETTLE ? quiet + 1 : quiet;
			if (!in_valid || in_ready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (req_q.size() == 0 || (req_q[0].drain && quiet < SETTLE)) begin
					in_valid <= 1'b0;
				end else begin
					it = req_q.pop_front();
					cur <= it;
					in_valid <= 1'b1;
					operation <= it.op;
					first_byte <= it.first;
					packet_len <= it.plen;
					data_byte <= it.data;
					hold_next = it.hold_out;
					gap_left <= req_q.size() != 0 ? req_q[0].gap : 0;
				end
			end
			hold_req <= hold_next;
		end
	end

	// receiver and result check
	always @(posedge clk or negedge arst_n) begin
		ring_res_t want;
		int pick;
		if (!arst_n) begin
			out_ready <= 1'b0;
			ready_left <= 0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_out.size() == 0) begin
					$error("result with nothing expected: kind %0d byte %0h", kind, out_byte);
					errors++;
				end else begin
					want = expected_out.pop_front();
					if (kind !== want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, kind);
						errors++;
					end
					if (out_byte !== want.data) begin
						$error("out_byte: expected %0h, got %0h", want.data, out_byte);
						errors++;
					end
					if (out_len !== want.plen) begin
						$error("out_len: expected %0d, got %0d", want.plen, out_len);
						errors++;
					end
					if (last_of_run !== want.last) begin
						$error("last_of_run: expected %0d, got %0d", want.last, last_of_run);
						errors++;
					end
				end
			end
			if (hold_req) begin
				out_ready <= 1'b0;
				ready_left <= LONG_HOLD;
			end else if (ready_left != 0) begin
				ready_left <= ready_left - 1;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 50) begin
					out_ready <= 1'b1;
					ready_left <= $urandom_range(0, 40);
				end else if (pick < 90) begin
					out_ready <= 1'b0;
					ready_left <= $urandom_range(0, 2);
				end else begin
					out_ready <= 1'b0;
					ready_left <= $urandom_range(10, 40);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stuck <= 0;
		else
			stuck <= stuck + 1;
		if (stuck == STUCK_LIMIT) begin
			$display("transfers stalled for %0d cycles", STUCK_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int pick;
		int len;
		int base;

		// empty ring, smallest and rejected lengths, stray and abandoned bytes
		queue_req(OP_POP, 1'b0, 7'd0, 8'h00);
		queue_req(OP_PUSH, 1'b1, 7'd1, 8'hFF);
		queue_req(OP_PUSH, 1'b1, 7'd0, 8'h00);
		queue_req(OP_PUSH, 1'b0, 7'h7F, 8'h11);
		queue_req(OP_PUSH, 1'b1, 7'd127, 8'hAA);
		queue_req(OP_PUSH, 1'b0, 7'd0, 8'h55);
		queue_req(OP_PUSH, 1'b0, 7'd0, 8'h55);
		queue_req(OP_PUSH, 1'b1, 7'd65, 8'h01);
		queue_req(OP_PUSH, 1'b1, 7'd3, 8'h00);
		queue_req(OP_PUSH, 1'b0, 7'd0, 8'h80);
		queue_req(OP_PUSH, 1'b1, 7'd2, 8'h7F);
		queue_req(OP_PUSH, 1'b0, 7'd0, 8'h01);
		queue_req(OP_PUSH, 1'b1, 7'd64, 8'h00);
		queue_req(OP_PUSH, 1'b1, 7'd2, 8'hFE);
		queue_req(OP_PUSH, 1'b0, 7'h2A, 8'hC3);
		queue_req(OP_POP, 1'b1, 7'h7F, 8'hFF);
		queue_req(OP_POP, 1'b0, 7'd0, 8'h00);
		queue_req(OP_POP, 1'b1, 7'h55, 8'h00);
		queue_req(OP_POP, 1'b0, 7'd0, 8'h00);

		next_drain = 1'b1;
		base = gen_items;
		while (gen_items < base + RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				len = $urandom_range(0, 99) < 85 ? $urandom_range(1, 8) :
					$urandom_range(0, 3) == 0 ? MAX_PKT : $urandom_range(9, MAX_PKT);
				queue_packet(7'(len), len);
			end else if (pick < 72) begin
				queue_pop();
			end else if (pick < 82) begin
				len = $urandom_range(2, 20);
				queue_packet(7'(len), $urandom_range(1, len - 1));
			end else if (pick < 89) begin
				len = $urandom_range(0, 1) ? 0 : $urandom_range(MAX_PKT + 1, 127);
				queue_packet(7'(len), $urandom_range(1, 6));
			end else if (pick < 94) begin
				queue_req(OP_PUSH, 1'b0, 7'($urandom), 8'($urandom));
			end else if (pick < 97) begin
				no_gaps = ~no_gaps;
			end else if (pick < 99) begin
				next_drain = 1'b1;
			end else begin
				next_hold = 1'b1;
			end
		end

		// long receiver hold while the sender keeps offering
		no_gaps = 1'b1;
		next_drain = 1'b1;
		next_hold = 1'b1;
		repeat (4)
			queue_packet(7'd4, 4);
		repeat (3)
			queue_pop();
		no_gaps = 1'b0;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (req_q.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_out.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("%0d input transfers, %0d result transfers: %0d packets stored, %0d rejected",
			items_sent, results_seen, n_push_ok, n_push_rej);
		$display("%0d rejected for lack of room, %0d bytes popped, %0d pops found nothing",
			n_room_rej, n_pop_bytes, n_pop_empty);
		if (errors == 0 && expected_out.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
